### rtl/wvo_pkg.sv
package wvo_pkg;

    // field widths
    localparam int OP_W       = 2;
    localparam int LEN_W      = 9;
    localparam int IDX_W      = 8;
    localparam int VALUE_W    = 16;
    localparam int STEP_W     = 32;
    localparam int GLIDE_W    = 32;
    localparam int EXPR_W     = 24;
    localparam int GAIN_W     = 16;
    localparam int COUNT_W    = 7;
    localparam int SAMPLE_W   = 24;
    localparam int FRAC_W     = 16;
    localparam int PHASE_W    = 24;

    // wave length limits
    localparam int LEN_MIN    = 2;
    localparam int LEN_MAX    = 256;

    // fixed point
    localparam int PROD1_W    = VALUE_W + GAIN_W + 1;
    localparam int PROD2_W    = PROD1_W + EXPR_W + 1;
    localparam int GPROD_W    = STEP_W + GLIDE_W;
    localparam int SHIFT      = 30;
    localparam logic [GLIDE_W-1:0] GLIDE_ONE = 32'h4000_0000;

    // remainder unit
    localparam int REM_NUM_W  = 16;
    localparam int REM_BITS   = 4;
    localparam int REM_ITERS  = REM_NUM_W / REM_BITS;
    localparam int REM_CNT_W  = $clog2(REM_ITERS);
    localparam int REM_W      = 8;

    // command queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [OP_W-1:0] {
        OP_LOAD    = 2'd0,
        OP_SEGMENT = 2'd1,
        OP_RENDER  = 2'd2
    } op_t;

    typedef struct packed {
        op_t                        kind;
        logic [IDX_W-1:0]           table_index;
        logic signed [VALUE_W-1:0]  table_value;
        logic [STEP_W-1:0]          phase_step;
        logic [GLIDE_W-1:0]         glide_factor;
        logic [EXPR_W-1:0]          start_expression;
        logic signed [EXPR_W-1:0]   expression_step;
        logic [GAIN_W-1:0]          gain;
        logic [COUNT_W-1:0]         frame_count;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PH_START,
        ST_PH_REM,
        ST_READ,
        ST_MUL1,
        ST_MUL2,
        ST_OUT
    } back_state_t;

endpackage

### rtl/wvo_rem_unit.sv
module wvo_rem_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [wvo_pkg::REM_NUM_W-1:0] numer,
    input  logic [wvo_pkg::LEN_W-1:0]     denom,
    output logic                          done,
    output logic [wvo_pkg::REM_W-1:0]     remainder
);
    import wvo_pkg::*;

    logic [REM_NUM_W-1:0] num_reg, num_next;
    logic [REM_W-1:0]     rem_reg, rem_next;
    logic [REM_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [REM_NUM_W-1:0] n_step;
    logic [REM_W-1:0]     r_step;

    // a few restoring remainder steps per cycle
    always_comb
    begin
        logic [LEN_W-1:0] t;
        n_step = num_reg;
        r_step = rem_reg;
        for (int i = 0; i < REM_BITS; i++)
        begin
            t = {r_step, n_step[REM_NUM_W-1]};
            n_step = {n_step[REM_NUM_W-2:0], 1'b0};
            if (t >= denom)
            begin
                t = t - denom;
            end
            r_step = t[REM_W-1:0];
        end
    end

    // sequencing
    always_comb
    begin
        num_next  = num_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        if (start)
        begin
            num_next  = numer;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
            done_next = 1'b0;
        end
        else if (busy_reg)
        begin
            num_next = n_step;
            rem_next = r_step;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == REM_CNT_W'(REM_ITERS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

### rtl/wvo_front.sv
module wvo_front #(
    parameter int TABLE_DEPTH = 256,
    parameter int MAX_FRAMES  = 64
) (
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [wvo_pkg::OP_W-1:0]           op,
    input  logic [wvo_pkg::IDX_W-1:0]          table_index,
    input  logic signed [wvo_pkg::VALUE_W-1:0] table_value,
    input  logic [wvo_pkg::STEP_W-1:0]         phase_step,
    input  logic [wvo_pkg::GLIDE_W-1:0]        glide_factor,
    input  logic [wvo_pkg::EXPR_W-1:0]         start_expression,
    input  logic signed [wvo_pkg::EXPR_W-1:0]  expression_step,
    input  logic [wvo_pkg::GAIN_W-1:0]         gain,
    input  logic [wvo_pkg::COUNT_W-1:0]        frame_count,
    input  logic                               queue_full,
    output logic                               push,
    output wvo_pkg::cmd_t                      push_cmd
);
    import wvo_pkg::*;

    logic keep;

    assign in_ready = !queue_full;

    // classify the request: drop what has no effect
    always_comb
    begin
        unique case (op_t'(op))
            OP_LOAD:    keep = (32'(table_index) < TABLE_DEPTH);
            OP_SEGMENT: keep = 1'b1;
            OP_RENDER:  keep = (frame_count != '0);
            default:    keep = 1'b0;
        endcase
    end

    assign push = in_valid && !queue_full && keep;

    // pack the command, clamp the frame count
    always_comb
    begin
        push_cmd.kind             = op_t'(op);
        push_cmd.table_index      = table_index;
        push_cmd.table_value      = table_value;
        push_cmd.phase_step       = phase_step;
        push_cmd.glide_factor     = glide_factor;
        push_cmd.start_expression = start_expression;
        push_cmd.expression_step  = expression_step;
        push_cmd.gain             = gain;
        if (32'(frame_count) > MAX_FRAMES)
        begin
            push_cmd.frame_count = COUNT_W'(MAX_FRAMES);
        end
        else
        begin
            push_cmd.frame_count = frame_count;
        end
    end

endmodule

### rtl/wvo_cmd_queue.sv
module wvo_cmd_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  wvo_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          empty,
    output wvo_pkg::cmd_t head
);
    import wvo_pkg::*;

    cmd_t              q_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = q_mem[rd_ptr_reg];

    // pointer and fill update
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

### rtl/wvo_back.sv
module wvo_back #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [wvo_pkg::LEN_W-1:0]           wave_length,
    input  logic                                queue_empty,
    input  wvo_pkg::cmd_t                       head,
    output logic                                pop,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [wvo_pkg::SAMPLE_W-1:0] sample,
    output logic                                last
);
    import wvo_pkg::*;

    localparam int LEN_CAP   = (TABLE_DEPTH < LEN_MAX) ? TABLE_DEPTH : LEN_MAX;
    localparam int MEM_DEPTH = LEN_CAP;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);
    localparam int MOD_W     = LEN_W + FRAC_W;
    localparam int SSUM_W    = PROD2_W + 1;
    localparam int SSH_W     = SSUM_W - SHIFT;
    localparam int GSUM_W    = GPROD_W + 1;
    localparam int GSH_W     = GSUM_W - SHIFT;
    localparam int ESUM_W    = EXPR_W + 2;

    back_state_t state_reg, state_next;

    // voice state
    logic [PHASE_W-1:0]        phase_acc_reg, phase_acc_next;
    logic [STEP_W-1:0]         cur_step_reg, cur_step_next;
    logic [GLIDE_W-1:0]        cur_glide_reg, cur_glide_next;
    logic [EXPR_W-1:0]         cur_expr_reg, cur_expr_next;
    logic signed [EXPR_W-1:0]  cur_estep_reg, cur_estep_next;
    logic [GAIN_W-1:0]         cur_gain_reg, cur_gain_next;
    logic [COUNT_W-1:0]        frames_left_reg, frames_left_next;

    // datapath
    logic [REM_W-1:0]          ph_red_reg;
    logic signed [VALUE_W-1:0] rd_data_reg;
    logic signed [PROD1_W-1:0] prod1_reg, prod1_next;
    logic signed [PROD2_W-1:0] prod2_reg, prod2_next;
    logic [GPROD_W-1:0]        gprod_reg, gprod_next;

    // output stage
    logic                       out_valid_reg, out_valid_next;
    logic signed [SAMPLE_W-1:0] sample_reg, sample_next;
    logic                       last_reg, last_next;

    logic signed [VALUE_W-1:0] wave_mem [MEM_DEPTH];

    logic [LEN_W-1:0]     eff_len;
    logic [MOD_W-1:0]     modulus;
    logic                 slot_free;
    logic                 emit;
    logic                 mem_we;
    logic                 mem_re;
    logic                 rem_start;
    logic [REM_NUM_W-1:0] rem_num;
    logic                 rem_done;
    logic [REM_W-1:0]     rem_out;

    logic signed [SSUM_W-1:0] ssum;
    logic signed [SSH_W-1:0]  ssh;
    logic [GSUM_W-1:0]        gsum;
    logic [GSH_W-1:0]         gsh;
    logic [MOD_W-1:0]         psum;
    logic signed [ESUM_W-1:0] esum;

    wvo_rem_unit u_rem (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (rem_start),
        .numer     (rem_num),
        .denom     (eff_len),
        .done      (rem_done),
        .remainder (rem_out)
    );

    // effective wave length
    always_comb
    begin
        if (wave_length < LEN_W'(LEN_MIN))
        begin
            eff_len = LEN_W'(LEN_MIN);
        end
        else if (wave_length > LEN_W'(LEN_CAP))
        begin
            eff_len = LEN_W'(LEN_CAP);
        end
        else
        begin
            eff_len = wave_length;
        end
    end

    assign modulus   = {eff_len, FRAC_W'(0)};
    assign slot_free = !out_valid_reg || out_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!queue_empty && head.kind == OP_RENDER)
                begin
                    state_next = ST_PH_START;
                end
            end
            ST_PH_START: state_next = ST_PH_REM;
            ST_PH_REM:
            begin
                if (rem_done)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ: state_next = ST_MUL1;
            ST_MUL1: state_next = ST_MUL2;
            ST_MUL2: state_next = ST_OUT;
            ST_OUT:
            begin
                if (emit)
                begin
                    state_next = (frames_left_reg == COUNT_W'(1)) ? ST_IDLE : ST_PH_START;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        pop       = 1'b0;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        rem_start = 1'b0;
        rem_num   = {8'd0, phase_acc_reg[PHASE_W-1:FRAC_W]};
        emit      = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                pop    = !queue_empty;
                mem_we = !queue_empty && head.kind == OP_LOAD;
            end
            ST_PH_START: rem_start = 1'b1;
            ST_PH_REM:
            begin
                rem_start = rem_done;
                rem_num   = cur_step_reg[STEP_W-1:FRAC_W];
            end
            ST_READ: mem_re = 1'b1;
            ST_OUT:  emit = rem_done && slot_free;
            default:
            begin
            end
        endcase
    end

    // round and saturate the sample
    always_comb
    begin
        ssum = SSUM_W'(prod2_reg) + SSUM_W'(1 <<< (SHIFT - 1));
        ssh  = ssum[SSUM_W-1:SHIFT];
        if (ssh > SSH_W'((1 <<< (SAMPLE_W - 1)) - 1))
        begin
            sample_next = {1'b0, {(SAMPLE_W-1){1'b1}}};
        end
        else if (ssh < -SSH_W'(1 <<< (SAMPLE_W - 1)))
        begin
            sample_next = {1'b1, {(SAMPLE_W-1){1'b0}}};
        end
        else
        begin
            sample_next = ssh[SAMPLE_W-1:0];
        end
    end

    // voice state update
    always_comb
    begin
        gsum = GSUM_W'(gprod_reg) + GSUM_W'(1 <<< (SHIFT - 1));
        gsh  = gsum[GSUM_W-1:SHIFT];
        psum = {1'b0, ph_red_reg, phase_acc_reg[FRAC_W-1:0]}
             + {1'b0, rem_out, cur_step_reg[FRAC_W-1:0]};
        esum = $signed({2'b00, cur_expr_reg}) + ESUM_W'(cur_estep_reg);

        phase_acc_next   = phase_acc_reg;
        cur_step_next    = cur_step_reg;
        cur_glide_next   = cur_glide_reg;
        cur_expr_next    = cur_expr_reg;
        cur_estep_next   = cur_estep_reg;
        cur_gain_next    = cur_gain_reg;
        frames_left_next = frames_left_reg;

        if (pop && head.kind == OP_SEGMENT)
        begin
            cur_step_next  = head.phase_step;
            cur_glide_next = head.glide_factor;
            cur_expr_next  = head.start_expression;
            cur_estep_next = head.expression_step;
            cur_gain_next  = head.gain;
        end
        if (pop && head.kind == OP_RENDER)
        begin
            frames_left_next = head.frame_count;
        end
        if (emit)
        begin
            frames_left_next = frames_left_reg - 1'b1;
            if (psum >= modulus)
            begin
                psum = psum - modulus;
            end
            phase_acc_next = psum[PHASE_W-1:0];
            if (gsh[GSH_W-1:STEP_W] != '0)
            begin
                cur_step_next = '1;
            end
            else
            begin
                cur_step_next = gsh[STEP_W-1:0];
            end
            if (esum < 0)
            begin
                cur_expr_next = '0;
            end
            else if (esum[EXPR_W] || esum[EXPR_W+1])
            begin
                cur_expr_next = '1;
            end
            else
            begin
                cur_expr_next = esum[EXPR_W-1:0];
            end
        end
    end

    // products
    always_comb
    begin
        prod1_next = rd_data_reg * $signed({1'b0, cur_gain_reg});
        prod2_next = prod1_reg * $signed({1'b0, cur_expr_reg});
        gprod_next = cur_step_reg * cur_glide_reg;
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        last_next      = last_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            last_next      = (frames_left_reg == COUNT_W'(1));
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            phase_acc_reg   <= '0;
            cur_step_reg    <= '0;
            cur_glide_reg   <= GLIDE_ONE;
            cur_expr_reg    <= '0;
            cur_estep_reg   <= '0;
            cur_gain_reg    <= '0;
            frames_left_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            phase_acc_reg   <= phase_acc_next;
            cur_step_reg    <= cur_step_next;
            cur_glide_reg   <= cur_glide_next;
            cur_expr_reg    <= cur_expr_next;
            cur_estep_reg   <= cur_estep_next;
            cur_gain_reg    <= cur_gain_next;
            frames_left_reg <= frames_left_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_PH_REM && rem_done)
        begin
            ph_red_reg <= rem_out;
        end
        if (state_reg == ST_MUL1)
        begin
            prod1_reg <= prod1_next;
            gprod_reg <= gprod_next;
        end
        if (state_reg == ST_MUL2)
        begin
            prod2_reg <= prod2_next;
        end
        if (emit)
        begin
            sample_reg <= sample_next;
            last_reg   <= last_next;
        end
    end

    // wave table
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            wave_mem[ADDR_W'(head.table_index)] <= head.table_value;
        end
        if (mem_re)
        begin
            rd_data_reg <= wave_mem[ADDR_W'(ph_red_reg)];
        end
    end

    assign out_valid = out_valid_reg;
    assign sample    = sample_reg;
    assign last      = last_reg;

    // the step remainder is still running while the table is read
    a_rem_busy_in_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |-> !rem_done)
        else $error("remainder unit idle during table read");

    a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |-> ({1'b0, ph_red_reg} < eff_len))
        else $error("table index beyond wave length");

    a_phase_wrapped: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> ({1'b0, phase_acc_reg} < $past(modulus)))
        else $error("phase not reduced after advance");

    a_frames_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> (frames_left_reg != '0))
        else $error("render running with no frames left");

endmodule

### rtl/wavetable_voice_oscillator.sv
// one wavetable synthesizer voice
//
// request channel (in_valid/in_ready): op selects load of one table word,
// a segment setup (step, glide, expression and its ramp, gain) or a render
// of frame_count samples. load and segment requests give no output.
// output channel (out_valid/out_ready): one sample per rendered frame, with
// last set on the final sample of each render run.
// wave_length is written through its own valid/ready port; the user must
// write it only while idle, the block itself does not enforce this.
// requests pass through a two-entry command queue, so new requests are taken
// while the back end is rendering or the output is stalled, until the queue
// is full. for a rendered sample the shared remainder unit reduces the
// integer phase and then the integer step modulo the wave length, around the
// table read and two multiplier stages. load and segment requests are taken
// by the back end in its idle state. a stalled receiver holds the output
// register, and the back end then waits before writing the next sample.
// reset clears phase, step, expression and gain, sets the glide to 1.0 and
// wave_length to 256; table contents are undefined until written.
module wavetable_voice_oscillator #(
    parameter int TABLE_DEPTH = 256,
    parameter int MAX_FRAMES  = 64
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [wvo_pkg::LEN_W-1:0]            wave_length,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [wvo_pkg::OP_W-1:0]             op,
    input  logic [wvo_pkg::IDX_W-1:0]            table_index,
    input  logic signed [wvo_pkg::VALUE_W-1:0]   table_value,
    input  logic [wvo_pkg::STEP_W-1:0]           phase_step,
    input  logic [wvo_pkg::GLIDE_W-1:0]          glide_factor,
    input  logic [wvo_pkg::EXPR_W-1:0]           start_expression,
    input  logic signed [wvo_pkg::EXPR_W-1:0]    expression_step,
    input  logic [wvo_pkg::GAIN_W-1:0]           gain,
    input  logic [wvo_pkg::COUNT_W-1:0]          frame_count,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [wvo_pkg::SAMPLE_W-1:0]  sample,
    output logic                                 last
);
    import wvo_pkg::*;

    logic [LEN_W-1:0] wave_length_reg, wave_length_next;
    logic             push;
    cmd_t             push_cmd;
    logic             queue_full;
    logic             queue_empty;
    logic             pop;
    cmd_t             head;

    // wave length register
    assign cfg_ready = 1'b1;

    always_comb
    begin
        wave_length_next = cfg_valid ? wave_length : wave_length_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wave_length_reg <= LEN_W'(LEN_MAX);
        end
        else
        begin
            wave_length_reg <= wave_length_next;
        end
    end

    wvo_front #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .MAX_FRAMES  (MAX_FRAMES)
    ) u_front (
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .op               (op),
        .table_index      (table_index),
        .table_value      (table_value),
        .phase_step       (phase_step),
        .glide_factor     (glide_factor),
        .start_expression (start_expression),
        .expression_step  (expression_step),
        .gain             (gain),
        .frame_count      (frame_count),
        .queue_full       (queue_full),
        .push             (push),
        .push_cmd         (push_cmd)
    );

    wvo_cmd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (queue_full),
        .pop      (pop),
        .empty    (queue_empty),
        .head     (head)
    );

    wvo_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .wave_length (wave_length_reg),
        .queue_empty (queue_empty),
        .head        (head),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .sample      (sample),
        .last        (last)
    );

endmodule
